/* rtl/core/hsrm_pkg.sv */
// shared types and constants for the hue/saturation range mask core
// no dependencies; compiled before the interfaces and the core
package hsrm_pkg;

   localparam int PIX_W     = 8;   // color component, hue and saturation width
   localparam int DIFF_W    = 12;  // signed hue sector numerator, up to five spreads
   localparam int TURN_W    = 16;  // hue numerator before doubling
   localparam int NUM_W     = 17;  // dividend and remainder width
   localparam int DEN_W     = 9;   // divisor width (twice an 8-bit value)
   localparam int DIV_STEPS = 8;   // one quotient bit per stage
   localparam int CSR_IDX_W = 2;

   localparam logic [PIX_W-1:0] HUE_SPAN       = 8'd180;
   localparam logic [PIX_W-1:0] HUE_LOW_RST    = 8'd160;
   localparam logic [PIX_W-1:0] HUE_HIGH_RST   = 8'd10;
   localparam logic [PIX_W-1:0] SAT_LOW_RST    = 8'd25;
   localparam logic [PIX_W-1:0] SAT_HIGH_RST   = 8'd166;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_LOW  = 2'd0,
      CSR_HUE_HIGH = 2'd1,
      CSR_SAT_LOW  = 2'd2,
      CSR_SAT_HIGH = 2'd3
   } csr_index_type;

endpackage

/* rtl/core/hsrm_if.sv */
// pixel and result stream interfaces with valid/ready handshake
// depends on hsrm_pkg
interface hsrm_req_if import hsrm_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;

   modport source(output valid, output blue, output green, output red, input ready);
   modport sink(input valid, input blue, input green, input red, output ready);
endinterface

interface hsrm_rsp_if import hsrm_pkg::*;;
   logic             valid;
   logic             ready;
   logic             in_range;
   logic [PIX_W-1:0] hue_value;
   logic [PIX_W-1:0] sat_value;

   modport source(output valid, output in_range, output hue_value, output sat_value,
                  input ready);
   modport sink(input valid, input in_range, input hue_value, input sat_value,
                output ready);
endinterface

/* rtl/core/hue_saturation_range_mask_core.sv */
// pipeline: 11 register stages; the result is shown on rsp_stream by the output stage
// and transfers there once rsp_stream.ready is high
// throughput: one pixel per cycle; every stage holds its item while the next one is full,
// so bubbles close up and the rate is set only by rsp_stream.ready
// the two 8-bit divisions run as restoring dividers, one quotient bit per stage
// reset: synchronous; clears all stage valid bits and restores the four thresholds
module hue_saturation_range_mask_core
   import hsrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_write_data,
   hsrm_req_if.sink             req_stream,
   hsrm_rsp_if.source           rsp_stream
);

   // stage map: 0 sector/extremes, 1 dividends, 2..9 divider bits, 10 threshold/output
   localparam int STAGE_CNT = DIV_STEPS + 3;
   localparam int DIV_BASE  = 2;
   localparam int OUT_STAGE = STAGE_CNT - 1;

   // ---------------------------------------------------------------- thresholds
   logic [PIX_W-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= HUE_LOW_RST;
         hue_high_ff <= HUE_HIGH_RST;
         sat_low_ff  <= SAT_LOW_RST;
         sat_high_ff <= SAT_HIGH_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_HUE_LOW:  hue_low_ff  <= csr_write_data;
            CSR_HUE_HIGH: hue_high_ff <= csr_write_data;
            CSR_SAT_LOW:  sat_low_ff  <= csr_write_data;
            CSR_SAT_HIGH: sat_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage control
   // a stage loads when it is empty or its content moves on this cycle
   logic [STAGE_CNT-1:0] valid_ff;
   logic [STAGE_CNT-1:0] valid_in;
   logic [STAGE_CNT-1:0] stage_en;

   assign stage_en[OUT_STAGE] = !valid_ff[OUT_STAGE] || rsp_stream.ready;
   for (genvar i = 0; i < OUT_STAGE; i++) begin : g_en
      assign stage_en[i] = !valid_ff[i] || stage_en[i+1];
   end

   assign valid_in         = {valid_ff[STAGE_CNT-2:0], req_stream.valid};
   assign req_stream.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGE_CNT; i++) begin
            if (stage_en[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- stage 0
   // max, spread and the hue sector numerator scaled by the spread
   logic [PIX_W-1:0]         max_c, min_c, spread;
   logic signed [DIFF_W-1:0] sb, sg, sr, sd, sector_num;
   logic [PIX_W-1:0]         s0_max_ff, s0_spread_ff;
   logic signed [DIFF_W-1:0] s0_num_ff;

   always_comb begin
      max_c = req_stream.red;
      min_c = req_stream.red;
      if (req_stream.green > max_c) max_c = req_stream.green;
      if (req_stream.blue  > max_c) max_c = req_stream.blue;
      if (req_stream.green < min_c) min_c = req_stream.green;
      if (req_stream.blue  < min_c) min_c = req_stream.blue;
      spread = max_c - min_c;
      sb = signed'(DIFF_W'(req_stream.blue));
      sg = signed'(DIFF_W'(req_stream.green));
      sr = signed'(DIFF_W'(req_stream.red));
      sd = signed'(DIFF_W'(spread));
      // red sector first, then green, then blue
      if (max_c == req_stream.red)
         sector_num = sg - sb;
      else if (max_c == req_stream.green)
         sector_num = sb - sr + (sd <<< 1);
      else
         sector_num = sr - sg + (sd <<< 2);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_max_ff    <= max_c;
         s0_spread_ff <= spread;
         s0_num_ff    <= sector_num;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // dividends and divisors for round-half-up quotients
   logic [DIFF_W-2:0] num_mag;
   logic [TURN_W-1:0] turn_mag, turn;
   logic [NUM_W-1:0]  hue_dividend, sat_dividend;
   logic [NUM_W-1:0]  s1_hue_rem_ff, s1_sat_rem_ff;
   logic [DEN_W-1:0]  s1_hue_den_ff, s1_sat_den_ff;
   logic              s1_gray_ff;

   always_comb begin
      num_mag  = s0_num_ff[DIFF_W-1] ? (DIFF_W-1)'(-s0_num_ff) : (DIFF_W-1)'(s0_num_ff);
      turn_mag = TURN_W'(num_mag) * TURN_W'(30);
      // negative hue wraps by a full turn (180 two-degree steps times the spread)
      turn = s0_num_ff[DIFF_W-1]
           ? TURN_W'(s0_spread_ff) * TURN_W'(180) - turn_mag
           : turn_mag;
      hue_dividend = {turn, 1'b0} + NUM_W'(s0_spread_ff);
      sat_dividend = NUM_W'(s0_spread_ff) * NUM_W'(510) + NUM_W'(s0_max_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_hue_rem_ff <= hue_dividend;
         s1_sat_rem_ff <= sat_dividend;
         s1_hue_den_ff <= {s0_spread_ff, 1'b0};
         s1_sat_den_ff <= {s0_max_ff, 1'b0};
         s1_gray_ff    <= (s0_spread_ff == '0);
      end
   end

   // ---------------------------------------------------------------- divider stages
   // restoring division, msb of the quotient first; both quotients stay below 256
   logic [NUM_W-1:0]     div_hue_rem_ff [DIV_STEPS];
   logic [NUM_W-1:0]     div_sat_rem_ff [DIV_STEPS];
   logic [DEN_W-1:0]     div_hue_den_ff [DIV_STEPS];
   logic [DEN_W-1:0]     div_sat_den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] div_hue_q_ff   [DIV_STEPS];
   logic [DIV_STEPS-1:0] div_sat_q_ff   [DIV_STEPS];
   logic                 div_gray_ff    [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam int SHIFT = DIV_STEPS - 1 - k;
      logic [NUM_W-1:0]     hue_rem_src, sat_rem_src, hue_trial, sat_trial;
      logic [DEN_W-1:0]     hue_den_src, sat_den_src;
      logic [DIV_STEPS-1:0] hue_q_src, sat_q_src;
      logic                 gray_src, hue_ge, sat_ge;

      if (k == 0) begin : g_first
         assign hue_rem_src = s1_hue_rem_ff;
         assign sat_rem_src = s1_sat_rem_ff;
         assign hue_den_src = s1_hue_den_ff;
         assign sat_den_src = s1_sat_den_ff;
         assign hue_q_src   = '0;
         assign sat_q_src   = '0;
         assign gray_src    = s1_gray_ff;
      end else begin : g_next
         assign hue_rem_src = div_hue_rem_ff[k-1];
         assign sat_rem_src = div_sat_rem_ff[k-1];
         assign hue_den_src = div_hue_den_ff[k-1];
         assign sat_den_src = div_sat_den_ff[k-1];
         assign hue_q_src   = div_hue_q_ff[k-1];
         assign sat_q_src   = div_sat_q_ff[k-1];
         assign gray_src    = div_gray_ff[k-1];
      end

      assign hue_trial = NUM_W'(hue_den_src) << SHIFT;
      assign sat_trial = NUM_W'(sat_den_src) << SHIFT;
      assign hue_ge    = (hue_rem_src >= hue_trial);
      assign sat_ge    = (sat_rem_src >= sat_trial);

      always_ff @(posedge clock) begin
         if (stage_en[DIV_BASE+k]) begin
            div_hue_rem_ff[k] <= hue_ge ? hue_rem_src - hue_trial : hue_rem_src;
            div_sat_rem_ff[k] <= sat_ge ? sat_rem_src - sat_trial : sat_rem_src;
            div_hue_den_ff[k] <= hue_den_src;
            div_sat_den_ff[k] <= sat_den_src;
            div_hue_q_ff[k]   <= {hue_q_src[DIV_STEPS-2:0], hue_ge};
            div_sat_q_ff[k]   <= {sat_q_src[DIV_STEPS-2:0], sat_ge};
            div_gray_ff[k]    <= gray_src;
         end
      end
   end

   // ---------------------------------------------------------------- output stage
   // gray pixels give zero hue and saturation; hue of 180 folds to 0
   logic [PIX_W-1:0] hue_c, sat_c;
   logic             hue_above, hue_below, hue_ok, sat_ok;
   logic             out_range_ff;
   logic [PIX_W-1:0] out_hue_ff, out_sat_ff;

   always_comb begin
      if (div_gray_ff[DIV_STEPS-1]) begin
         hue_c = '0;
         sat_c = '0;
      end else begin
         hue_c = (div_hue_q_ff[DIV_STEPS-1] == HUE_SPAN) ? '0 : div_hue_q_ff[DIV_STEPS-1];
         sat_c = div_sat_q_ff[DIV_STEPS-1];
      end
      hue_above = hue_c > hue_low_ff;
      hue_below = hue_c <= hue_high_ff;
      // a window whose low bound is not below its high bound wraps through zero
      hue_ok = (hue_low_ff < hue_high_ff) ? (hue_above && hue_below)
                                          : (hue_above || hue_below);
      sat_ok = (sat_c > sat_low_ff) && (sat_c <= sat_high_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[OUT_STAGE]) begin
         out_range_ff <= hue_ok && sat_ok;
         out_hue_ff   <= hue_c;
         out_sat_ff   <= sat_c;
      end
   end

   assign rsp_stream.valid     = valid_ff[OUT_STAGE];
   assign rsp_stream.in_range  = out_range_ff;
   assign rsp_stream.hue_value = out_hue_ff;
   assign rsp_stream.sat_value = out_sat_ff;

`ifndef SYNTHESIS
   // a transfer always lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_stream.valid && req_stream.ready) |=> valid_ff[0])
      else $error("accepted pixel missing from first stage");

   // the hue division must finish with a remainder below the divisor
   a_hue_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_BASE+DIV_STEPS-1] && !div_gray_ff[DIV_STEPS-1])
      |-> (div_hue_rem_ff[DIV_STEPS-1] < NUM_W'(div_hue_den_ff[DIV_STEPS-1])))
      else $error("hue divider remainder out of range");

   // folded hue never reaches a full turn
   a_hue_folded: assert property (@(posedge clock) disable iff (reset)
      rsp_stream.valid |-> (rsp_stream.hue_value < HUE_SPAN))
      else $error("hue not folded");

   // zero saturation can never pass the exclusive lower bound
   a_zero_sat_masked: assert property (@(posedge clock) disable iff (reset)
      (rsp_stream.valid && (rsp_stream.sat_value == '0)) |-> !rsp_stream.in_range)
      else $error("zero saturation flagged in range");
`endif

endmodule

/* bench/hsrm_mask_checker.sv */
// result checker for the hue/saturation range mask core: watches the pixel and result
// streams and the threshold writes, predicts every result and compares them in order
// depends on hsrm_pkg and the stream interfaces of hsrm_if.sv
module hsrm_mask_checker
   import hsrm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  csr_index_type    csr_index,
   input  logic [PIX_W-1:0] csr_write_data,
   hsrm_req_if              req_stream,
   hsrm_rsp_if              rsp_stream,
   output int               fail_count,
   output int               masks_pending,
   output int               masks_checked
);

   typedef struct packed {
      logic             in_range;
      logic [PIX_W-1:0] hue_value;
      logic [PIX_W-1:0] sat_value;
   } mask_result_type;

   logic [PIX_W-1:0] hue_low, hue_high, sat_low, sat_high;
   mask_result_type  pending_masks[$];
   int               pixels_in;

   assign masks_pending = pixels_in - masks_checked;

   // hsv conversion with round half up, then the two range tests
   function automatic mask_result_type classify_pixel(input logic [PIX_W-1:0] b, g, r);
      int              peak, trough, span, sector, turn, hue, sat;
      logic            hue_ok, sat_ok;
      mask_result_type res;
      peak = int'(r);
      trough = int'(r);
      if (int'(g) > peak) peak = int'(g);
      if (int'(b) > peak) peak = int'(b);
      if (int'(g) < trough) trough = int'(g);
      if (int'(b) < trough) trough = int'(b);
      span = peak - trough;
      if (span == 0) begin
         hue = 0;
         sat = 0;
      end else begin
         sat = (510 * span + peak) / (2 * peak);
         if (sat > 255) sat = 255;
         // red wins ties, then green
         if (int'(r) == peak) sector = int'(g) - int'(b);
         else if (int'(g) == peak) sector = int'(b) - int'(r) + 2 * span;
         else sector = int'(r) - int'(g) + 4 * span;
         turn = (sector < 0) ? 180 * span + 30 * sector : 30 * sector;
         hue = (2 * turn + span) / (2 * span);
         if (hue >= 180) hue = 0;
      end
      res.hue_value = hue[PIX_W-1:0];
      res.sat_value = sat[PIX_W-1:0];
      if (hue_low < hue_high)
         hue_ok = (res.hue_value > hue_low) && (res.hue_value <= hue_high);
      else
         hue_ok = (res.hue_value > hue_low) || (res.hue_value <= hue_high);
      sat_ok = (res.sat_value > sat_low) && (res.sat_value <= sat_high);
      res.in_range = hue_ok && sat_ok;
      return res;
   endfunction

   function automatic int field_error(input string field, input int want, input int got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : observe
      mask_result_type want;
      int              errors;
      if (reset) begin
         hue_low  = HUE_LOW_RST;
         hue_high = HUE_HIGH_RST;
         sat_low  = SAT_LOW_RST;
         sat_high = SAT_HIGH_RST;
         pending_masks.delete();
         pixels_in     <= 0;
         masks_checked <= 0;
         fail_count    <= 0;
      end else begin
         errors = 0;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HUE_LOW:  hue_low  = csr_write_data;
               CSR_HUE_HIGH: hue_high = csr_write_data;
               CSR_SAT_LOW:  sat_low  = csr_write_data;
               CSR_SAT_HIGH: sat_high = csr_write_data;
               default: ;
            endcase
         end
         if (req_stream.valid && req_stream.ready) begin
            pending_masks.push_back(classify_pixel(req_stream.blue, req_stream.green,
                                                   req_stream.red));
            pixels_in <= pixels_in + 1;
         end
         if (rsp_stream.valid && rsp_stream.ready) begin
            if (pending_masks.size() == 0) begin
               errors = 1;
               $display("%0t: result with none expected, expected nothing, actual %0d/%0d/%0d",
                        $time, rsp_stream.in_range, rsp_stream.hue_value,
                        rsp_stream.sat_value);
            end else begin
               want = pending_masks.pop_front();
               masks_checked <= masks_checked + 1;
               errors += field_error("in_range", want.in_range, rsp_stream.in_range);
               errors += field_error("hue_value", want.hue_value, rsp_stream.hue_value);
               errors += field_error("sat_value", want.sat_value, rsp_stream.sat_value);
            end
         end
         if (errors != 0) fail_count <= fail_count + errors;
      end
   end

endmodule

/* bench/hue_saturation_range_mask_core_tb.sv */
// top of the hue/saturation range mask bench: clock, reset, pixel stimulus, threshold
// writes, result back-pressure and the verdict; checking lives in hsrm_mask_checker
// depends on hsrm_pkg, hsrm_if.sv, hsrm_mask_checker and the core
module hue_saturation_range_mask_core_tb;
   import hsrm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 16;   // extra wait after the last result is checked
   localparam int MAX_GAP       = 14;
   localparam int PHASES        = 8;
   localparam int PHASE_PIXELS  = 130;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   csr_index_type    csr_index;
   logic [PIX_W-1:0] csr_write_data;
   logic             steady_run = 1'b0;   // both sides skip idling while set
   int               cycle_count = 0;
   int               pixels_sent = 0;
   int               settings_used = 1;   // reset thresholds count as the first
   int               fail_count, masks_pending, masks_checked;

   hsrm_req_if req_bus();
   hsrm_rsp_if rsp_bus();

   hue_saturation_range_mask_core uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_stream       (req_bus),
      .rsp_stream       (rsp_bus)
   );

   hsrm_mask_checker mask_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_stream       (req_bus),
      .rsp_stream       (rsp_bus),
      .fail_count       (fail_count),
      .masks_pending    (masks_pending),
      .masks_checked    (masks_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stuck after %0d cycles, %0d results still due", $time,
                  cycle_count, masks_pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // idle cycles before the next transfer on either side
   function automatic int draw_gap();
      if (steady_run) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // a component pinned to a rail or left free
   function automatic logic [PIX_W-1:0] rail_component();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // one pixel transfer; valid stays high when the next pixel follows without a gap
   task automatic send_pixel(input logic [PIX_W-1:0] b, g, r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.blue  <= b;
      req_bus.green <= g;
      req_bus.red   <= r;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      pixels_sent++;
   endtask

   // stop sending and wait until every result has been checked
   task automatic flush_pipeline();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (masks_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four thresholds back to back, only while the pipeline is empty
   task automatic load_thresholds(input logic [PIX_W-1:0] h_lo, h_hi, s_lo, s_hi);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_HUE_LOW;
      csr_write_data <= h_lo;
      @(posedge clock);
      csr_index <= CSR_HUE_HIGH;
      csr_write_data <= h_hi;
      @(posedge clock);
      csr_index <= CSR_SAT_LOW;
      csr_write_data <= s_lo;
      @(posedge clock);
      csr_index <= CSR_SAT_HIGH;
      csr_write_data <= s_hi;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // result side: random stalls between transfers, with stretches of steady ready
   initial begin : result_drain
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin : stimulus
      logic [PIX_W-1:0] b, g, r, base;
      logic [PIX_W-1:0] h_lo, h_hi, s_lo, s_hi;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.blue     <= '0;
      req_bus.green    <= '0;
      req_bus.red      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_HUE_LOW;
      csr_write_data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners under the reset thresholds (wrapped hue range)
      send_pixel(8'd0,   8'd0,   8'd0);     // black, no division
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
      send_pixel(8'd0,   8'd0,   8'd1);     // dimmest red, full saturation
      send_pixel(8'd0,   8'd0,   8'd255);   // red
      send_pixel(8'd0,   8'd255, 8'd0);     // green
      send_pixel(8'd255, 8'd0,   8'd0);     // blue
      send_pixel(8'd0,   8'd255, 8'd255);   // yellow, red and green tie
      send_pixel(8'd255, 8'd255, 8'd0);     // cyan, green and blue tie
      send_pixel(8'd255, 8'd0,   8'd255);   // magenta, red and blue tie
      send_pixel(8'd1,   8'd0,   8'd255);   // hue rounds to 180 and folds to 0
      send_pixel(8'd2,   8'd0,   8'd255);   // same fold a bit further down
      send_pixel(8'd0,   8'd1,   8'd255);   // hue just above 0, rounds down
      send_pixel(8'd0,   8'd5,   8'd255);   // first hue that rounds to 1
      send_pixel(8'd1,   8'd1,   8'd2);     // saturation exactly half, rounds up
      send_pixel(8'd0,   8'd1,   8'd4);     // hue exactly half, rounds up
      send_pixel(8'd250, 8'd250, 8'd255);   // near white, low saturation
      send_pixel(8'd255, 8'd0,   8'd128);   // blue sector with red above green
      send_pixel(8'd10,  8'd200, 8'd60);    // green sector
      send_pixel(8'd200, 8'd60,  8'd10);    // blue sector with green above red
      flush_pipeline();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_thresholds(8'd0,   8'd180, 8'd0,   8'd255);  // widest plain range
            1: load_thresholds(8'd0,   8'd0,   8'd0,   8'd255);  // equal bounds wrap to all
            2: load_thresholds(8'd255, 8'd255, 8'd255, 8'd255);  // above range, sat never
            3: load_thresholds(8'd180, 8'd0,   8'd254, 8'd255);  // only hue 0, sat 255
            default: begin
               h_lo = PIX_W'($urandom_range(0, 180));
               h_hi = PIX_W'($urandom_range(0, 180));
               s_lo = PIX_W'($urandom_range(0, 200));
               s_hi = PIX_W'($urandom_range(s_lo, 255));
               load_thresholds(h_lo, h_hi, s_lo, s_hi);
            end
         endcase
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (n % 40 == 0) steady_run = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
               0, 1: begin
                  // near gray: tiny spans stress the rounding
                  base = PIX_W'($urandom);
                  b = base;
                  g = base ^ PIX_W'($urandom_range(0, 3));
                  r = base ^ PIX_W'($urandom_range(0, 3));
               end
               2, 3: begin
                  b = rail_component();
                  g = rail_component();
                  r = rail_component();
               end
               default: begin
                  b = PIX_W'($urandom);
                  g = PIX_W'($urandom);
                  r = PIX_W'($urandom);
               end
            endcase
            send_pixel(b, g, r);
         end
         steady_run = 1'b0;
         // sender holds off until every result is back
         flush_pipeline();
      end

      $display("covered %0d pixels under %0d threshold settings, %0d results compared",
               pixels_sent, settings_used, masks_checked);
      $display("including gray and black pixels, primaries, hue fold and wrapped ranges");
      if (fail_count == 0 && masks_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
